// ===== hw/rtl/twca_pkg.sv =====
// ----------------------------------------------------------------------------
// twca_pkg - shared types and constants for the current averager
// Field widths, request codes and register indexes.
// ----------------------------------------------------------------------------
package twca_pkg;

    localparam int READING_BITS_DEF = 10;

    localparam int ELAPSED_W = 24;
    localparam int READING_W = 10;
    localparam int STAMP_W   = 32;
    localparam int AVG_W     = 18;
    localparam int MIN_INT_W = 16;
    localparam int WPU_W     = 24;
    localparam int WEIGHT_W  = 24;
    localparam int DEN_W     = 25;
    localparam int NUM_W     = 42;
    localparam int ACC_W     = 48;
    localparam int CNT_W     = 6;
    localparam int CFG_W     = 24;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } t_op;

    typedef enum logic {
        CFG_MIN_INTERVAL  = 1'b0,
        CFG_WEIGHT_PER_US = 1'b1
    } t_cfg_index;

    localparam logic [WPU_W-1:0] WPU_RESET = 24'h010000;

endpackage

// ===== hw/rtl/time_weighted_current_average.sv =====
// A sample request is taken in S_IDLE, then 24 multiply steps for the weight,
// 1 saturate step, 18 multiply steps for the numerator and 42 divide steps, all
// on one shared 48-bit add/subtract unit; a clear or ignored request goes straight
// to S_DONE. The next request is taken once the result has left S_DONE.
// The output register lets the next request in while a result waits.
// Synchronous active-low reset clears average, peak, stamp, minimum interval and output valid, and sets weight per us.
// ----------------------------------------------------------------------------
// time_weighted_current_average - motor-current running average with peak
// Weighted average of ADC readings, weight grows with elapsed time;
// division by an iterative restoring divider on a shared adder.
// ----------------------------------------------------------------------------
module time_weighted_current_average
    import twca_pkg::*;
#(
    parameter int READING_BITS = READING_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_op,
    input  logic [ELAPSED_W-1:0] i_elapsed_us,
    input  logic [READING_W-1:0] i_reading,
    input  logic [STAMP_W-1:0]   i_sample_stamp,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_accepted,
    output logic [AVG_W-1:0]     o_average,
    output logic [AVG_W-1:0]     o_peak
);

    // readings wider than the port are limited by the port itself
    localparam int RD_USE = (READING_BITS < READING_W) ? READING_BITS : READING_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_W,
        S_SAT,
        S_MUL_N,
        S_DIV,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [MIN_INT_W-1:0]   r_min_interval;
    logic [WPU_W-1:0]       r_wpu;
    logic [AVG_W-1:0]       r_avg;
    logic [AVG_W-1:0]       r_peak;
    logic [STAMP_W-1:0]     r_stamp;
    logic [READING_W-1:0]   r_reading;
    logic [ACC_W-1:0]       r_acc;
    logic [ACC_W-1:0]       r_mc;
    logic [WPU_W-1:0]       r_mr;
    logic [DEN_W-1:0]       r_den;
    logic [DEN_W-1:0]       r_rem;
    logic [NUM_W-1:0]       r_nq;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_res_acc;
    logic                   r_out_valid;
    logic                   r_accepted;
    logic [AVG_W-1:0]       r_average;
    logic [AVG_W-1:0]       r_peak_out;

    logic [READING_W-1:0]   w_reading;
    logic [WEIGHT_W-1:0]    w_weight;
    logic [DEN_W:0]         w_rem_sh;
    logic [ACC_W-1:0]       u_a;
    logic [ACC_W-1:0]       u_b;
    logic                   u_sub;
    logic [ACC_W-1:0]       u_sum;
    logic                   w_borrow;
    logic [DEN_W-1:0]       n_rem;
    logic [NUM_W-1:0]       n_nq;
    logic [AVG_W-1:0]       n_avg;
    logic                   w_take;

    assign w_reading = READING_W'(i_reading[RD_USE-1:0]);
    assign w_take    = i_in_valid && (r_state == S_IDLE);

    // weight = product >> 8, saturated to 24 bits
    assign w_weight = (|r_acc[ACC_W-1:WEIGHT_W+8]) ? {WEIGHT_W{1'b1}}
                                                  : r_acc[WEIGHT_W+7:8];

    assign w_rem_sh = {r_rem, r_nq[NUM_W-1]};

    // shared add/subtract unit
    always_comb begin
        u_a   = r_acc;
        u_b   = '0;
        u_sub = 1'b0;
        unique case (r_state)
            S_MUL_W, S_MUL_N: begin
                u_a = r_acc;
                u_b = r_mr[0] ? r_mc : '0;
            end
            S_SAT: begin
                u_a = ACC_W'(w_weight);
                u_b = ACC_W'(256);
            end
            S_DIV: begin
                u_a   = ACC_W'(w_rem_sh);
                u_b   = ACC_W'(r_den);
                u_sub = 1'b1;
            end
            default: begin
                u_a = r_acc;
            end
        endcase
    end

    assign u_sum    = u_sub ? (u_a - u_b) : (u_a + u_b);
    assign w_borrow = u_sum[ACC_W-1];
    assign n_rem    = w_borrow ? w_rem_sh[DEN_W-1:0] : u_sum[DEN_W-1:0];
    assign n_nq     = {r_nq[NUM_W-2:0], ~w_borrow};
    assign n_avg    = (|n_nq[NUM_W-1:AVG_W]) ? {AVG_W{1'b1}} : n_nq[AVG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_min_interval <= '0;
            r_wpu          <= WPU_RESET;
            r_avg          <= '0;
            r_peak         <= '0;
            r_stamp        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_MIN_INTERVAL:  r_min_interval <= i_cfg_data[MIN_INT_W-1:0];
                    CFG_WEIGHT_PER_US: r_wpu          <= i_cfg_data[WPU_W-1:0];
                endcase
            end

            // a waiting result about to be replaced is handled in S_DONE
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        if (t_op'(i_op) == OP_CLEAR) begin
                            r_avg     <= '0;
                            r_peak    <= '0;
                            r_stamp   <= '0;
                            r_res_acc <= 1'b0;
                            r_state   <= S_DONE;
                        end else if (i_elapsed_us >= ELAPSED_W'(r_min_interval)
                                     && i_sample_stamp != r_stamp) begin
                            r_stamp   <= i_sample_stamp;
                            r_reading <= w_reading;
                            r_acc     <= '0;
                            r_mc      <= ACC_W'(i_elapsed_us);
                            r_mr      <= r_wpu;
                            r_cnt     <= CNT_W'(WPU_W);
                            r_res_acc <= 1'b1;
                            r_state   <= S_MUL_W;
                        end else begin
                            r_res_acc <= 1'b0;
                            r_state   <= S_DONE;
                        end
                    end
                end
                S_MUL_W, S_MUL_N: begin
                    r_acc <= u_sum;
                    r_mc  <= {r_mc[ACC_W-2:0], 1'b0};
                    r_mr  <= {1'b0, r_mr[WPU_W-1:1]};
                    if (r_cnt == CNT_W'(1)) begin
                        if (r_state == S_MUL_W) begin
                            r_state <= S_SAT;
                        end else begin
                            r_nq    <= u_sum[NUM_W-1:0];
                            r_rem   <= '0;
                            r_cnt   <= CNT_W'(NUM_W);
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_SAT: begin
                    // denominator and numerator seed reading << 16
                    r_den   <= u_sum[DEN_W-1:0];
                    r_acc   <= ACC_W'({r_reading, 16'h0000});
                    r_mc    <= ACC_W'(w_weight);
                    r_mr    <= WPU_W'(r_avg);
                    r_cnt   <= CNT_W'(AVG_W);
                    r_state <= S_MUL_N;
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_nq  <= n_nq;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_avg <= n_avg;
                        if (n_avg > r_peak) begin
                            r_peak <= n_avg;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_accepted  <= r_res_acc;
                        r_average   <= r_avg;
                        r_peak_out  <= r_peak;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_accepted;
    assign o_average   = r_average;
    assign o_peak      = r_peak_out;

endmodule
